// ----- design/bcd_clock_alarm_countdown_unit_assert.svh -----
// Assertion macros for the BCD clock unit.
`ifndef BCD_CLOCK_ALARM_COUNTDOWN_UNIT_ASSERT_SVH
`define BCD_CLOCK_ALARM_COUNTDOWN_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define BCAC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bcac check failed");

// next-cycle implication, checked out of reset
`define BCAC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bcac check failed");

`endif

// ----- design/bcac_pkg.sv -----
package bcac_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;
    localparam int ADDR_W     = 7;

    localparam logic [ADDR_W-1:0] MSG_END  = 7'h60;
    localparam logic [3:0]        DIGIT_MAX = 4'd9;
    localparam logic [2:0]        MIN_TENS_MAX = 3'd5;
    localparam logic [3:0]        SEC_TENS_MAX = 4'd5;

    typedef enum logic [1:0] {
        REQ_MINUTE = 2'd0,
        REQ_SECOND = 2'd1,
        REQ_ADJUST = 2'd2,
        REQ_LOAD   = 2'd3
    } t_req_type;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALARM_HOUR_TENS  = 2'd0,
        CFG_ALARM_HOUR_UNITS = 2'd1,
        CFG_ALARM_MIN_TENS   = 2'd2,
        CFG_ALARM_MIN_UNITS  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0] req_type;
        logic [3:0] load_min_tens;
        logic [3:0] load_min_units;
        logic [3:0] load_sec_tens;
        logic [3:0] load_sec_units;
    } t_item;

    typedef struct packed {
        logic [1:0]        hour_tens;
        logic [3:0]        hour_units;
        logic [2:0]        minute_tens;
        logic [3:0]        minute_units;
        logic [3:0]        count_min_tens;
        logic [3:0]        count_min_units;
        logic [3:0]        count_sec_tens;
        logic [3:0]        count_sec_units;
        logic              play_request;
        logic [ADDR_W-1:0] play_address;
        logic              countdown_running;
    } t_result;

    function automatic logic [3:0] clamp9(input logic [3:0] v);
        return (v > DIGIT_MAX) ? DIGIT_MAX : v;
    endfunction

    // binary hour 0..23 from BCD digits
    function automatic logic [4:0] hour_bin(input logic [1:0] ht, input logic [3:0] hu);
        return ({3'b000, ht} << 3) + ({3'b000, ht} << 1) + {1'b0, hu};
    endfunction

endpackage

// ----- design/bcac_item_if.sv -----
interface bcac_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [3:0] load_min_tens;
    logic [3:0] load_min_units;
    logic [3:0] load_sec_tens;
    logic [3:0] load_sec_units;

    modport source (
        output valid, req_type, load_min_tens, load_min_units, load_sec_tens, load_sec_units,
        input  ready
    );
    modport sink (
        input  valid, req_type, load_min_tens, load_min_units, load_sec_tens, load_sec_units,
        output ready
    );
endinterface

// ----- design/bcac_result_if.sv -----
interface bcac_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] hour_tens;
    logic [3:0] hour_units;
    logic [2:0] minute_tens;
    logic [3:0] minute_units;
    logic [3:0] count_min_tens;
    logic [3:0] count_min_units;
    logic [3:0] count_sec_tens;
    logic [3:0] count_sec_units;
    logic       play_request;
    logic [6:0] play_address;
    logic       countdown_running;

    modport source (
        output valid, hour_tens, hour_units, minute_tens, minute_units,
               count_min_tens, count_min_units, count_sec_tens, count_sec_units,
               play_request, play_address, countdown_running,
        input  ready
    );
    modport sink (
        input  valid, hour_tens, hour_units, minute_tens, minute_units,
               count_min_tens, count_min_units, count_sec_tens, count_sec_units,
               play_request, play_address, countdown_running,
        output ready
    );
endinterface

// ----- design/bcd_clock_alarm_countdown_unit.sv -----
// BCD 24-hour HH:MM clock (reset 23:59) with an alarm and an MM:SS countdown.
// Every input beat gives exactly one result beat showing the state after it.
// A beat is taken into an input register and, once the skid entry is free,
// run through one pass of digit logic into a two-entry output buffer (result
// plus skid), so one beat is accepted every cycle while the output side keeps
// up. The user must write alarm registers through i_cfg_* only while no beat
// is in flight; the block itself does not enforce this.
module bcd_clock_alarm_countdown_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bcac_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bcac_pkg::CFG_DATA_W-1:0] i_cfg_data,
    bcac_item_if.sink                       i_item,
    bcac_result_if.source                   o_result
);
    import bcac_pkg::*;

    `include "bcd_clock_alarm_countdown_unit_assert.svh"

    logic [1:0] r_al_ht;
    logic [3:0] r_al_hu;
    logic [2:0] r_al_mt;
    logic [3:0] r_al_mu;

    logic [1:0] r_ht, n_ht;
    logic [3:0] r_hu, n_hu;
    logic [2:0] r_mt, n_mt;
    logic [3:0] r_mu, n_mu;
    logic [3:0] r_dmt, n_dmt;
    logic [3:0] r_dmu, n_dmu;
    logic [3:0] r_dst, n_dst;
    logic [3:0] r_dsu, n_dsu;
    logic       r_act, n_act;

    logic    r_in_valid;
    t_item   r_in;
    logic    r_o_valid;
    t_result r_o;
    logic    r_s_valid;
    t_result r_s;

    t_result res;
    logic    push;
    logic    pop;
    logic    in_fire;

    assign push    = r_in_valid && !r_s_valid;
    assign pop     = r_o_valid && o_result.ready;
    assign i_item.ready = !r_in_valid || push;
    assign in_fire = i_item.valid && i_item.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_al_ht <= '0;
            r_al_hu <= '0;
            r_al_mt <= '0;
            r_al_mu <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ALARM_HOUR_TENS:  r_al_ht <= i_cfg_data[1:0];
                CFG_ALARM_HOUR_UNITS: r_al_hu <= i_cfg_data;
                CFG_ALARM_MIN_TENS:   r_al_mt <= i_cfg_data[2:0];
                CFG_ALARM_MIN_UNITS:  r_al_mu <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        logic       top;
        logic [4:0] hb;
        n_ht  = r_ht;
        n_hu  = r_hu;
        n_mt  = r_mt;
        n_mu  = r_mu;
        n_dmt = r_dmt;
        n_dmu = r_dmu;
        n_dst = r_dst;
        n_dsu = r_dsu;
        n_act = r_act;
        top   = 1'b0;
        hb    = '0;
        res   = '0;
        case (t_req_type'(r_in.req_type))
            REQ_MINUTE: begin
                if (r_mu < DIGIT_MAX) begin
                    n_mu = r_mu + 4'd1;
                end else begin
                    n_mu = '0;
                    if (r_mt < MIN_TENS_MAX) begin
                        n_mt = r_mt + 3'd1;
                    end else begin
                        n_mt = '0;
                        top  = 1'b1;
                        if (r_ht == 2'd2 && r_hu == 4'd3) begin
                            n_ht = '0;
                            n_hu = '0;
                        end else if (r_hu == DIGIT_MAX) begin
                            n_ht = r_ht + 2'd1;
                            n_hu = '0;
                        end else begin
                            n_hu = r_hu + 4'd1;
                        end
                    end
                end
                hb = hour_bin(n_ht, n_hu);
                if (top) begin
                    res.play_request = 1'b1;
                    res.play_address = {hb, 2'b00};
                end
                if (n_mu == r_al_mu && n_mt == r_al_mt && n_hu == r_al_hu && n_ht == r_al_ht) begin
                    res.play_request = 1'b1;
                    res.play_address = MSG_END;
                end
            end
            REQ_SECOND: begin
                if (r_act) begin
                    if (r_dmt == '0 && r_dmu == '0 && r_dst == '0 && r_dsu == '0) begin
                        res.play_request = 1'b1;
                        res.play_address = MSG_END;
                        n_act = 1'b0;
                    end else if (r_dsu != '0) begin
                        n_dsu = r_dsu - 4'd1;
                    end else begin
                        n_dsu = DIGIT_MAX;
                        if (r_dst != '0) begin
                            n_dst = r_dst - 4'd1;
                        end else begin
                            n_dst = SEC_TENS_MAX;
                            if (r_dmu != '0) begin
                                n_dmu = r_dmu - 4'd1;
                            end else begin
                                n_dmu = DIGIT_MAX;
                                if (r_dmt != '0) begin
                                    n_dmt = r_dmt - 4'd1;
                                end
                            end
                        end
                    end
                end
            end
            REQ_ADJUST: begin
                if (r_ht == 2'd2 && r_hu >= 4'd2) begin
                    n_ht = '0;
                    n_hu = r_hu - 4'd2;
                end else if (r_hu >= 4'd8) begin
                    n_ht = r_ht + 2'd1;
                    n_hu = r_hu - 4'd8;
                end else begin
                    n_hu = r_hu + 4'd2;
                end
            end
            REQ_LOAD: begin
                n_dmt = clamp9(r_in.load_min_tens);
                n_dmu = clamp9(r_in.load_min_units);
                n_dst = clamp9(r_in.load_sec_tens);
                n_dsu = clamp9(r_in.load_sec_units);
                n_act = 1'b1;
            end
            default: ;
        endcase
        res.hour_tens         = n_ht;
        res.hour_units        = n_hu;
        res.minute_tens       = n_mt;
        res.minute_units      = n_mu;
        res.count_min_tens    = n_dmt;
        res.count_min_units   = n_dmu;
        res.count_sec_tens    = n_dst;
        res.count_sec_units   = n_dsu;
        res.countdown_running = n_act;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ht  <= 2'd2;
            r_hu  <= 4'd3;
            r_mt  <= 3'd5;
            r_mu  <= 4'd9;
            r_dmt <= '0;
            r_dmu <= '0;
            r_dst <= '0;
            r_dsu <= '0;
            r_act <= 1'b0;
        end else if (push) begin
            r_ht  <= n_ht;
            r_hu  <= n_hu;
            r_mt  <= n_mt;
            r_mu  <= n_mu;
            r_dmt <= n_dmt;
            r_dmu <= n_dmu;
            r_dst <= n_dst;
            r_dsu <= n_dsu;
            r_act <= n_act;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (push) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in.req_type       <= i_item.req_type;
            r_in.load_min_tens  <= i_item.load_min_tens;
            r_in.load_min_units <= i_item.load_min_units;
            r_in.load_sec_tens  <= i_item.load_sec_tens;
            r_in.load_sec_units <= i_item.load_sec_units;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_s_valid <= 1'b0;
        end else if (pop) begin
            if (r_s_valid) begin
                r_s_valid <= 1'b0;
            end else begin
                r_o_valid <= push;
            end
        end else if (push) begin
            if (r_o_valid) begin
                r_s_valid <= 1'b1;
            end else begin
                r_o_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (r_s_valid) begin
                r_o <= r_s;
            end else if (push) begin
                r_o <= res;
            end
        end else if (push) begin
            if (r_o_valid) begin
                r_s <= res;
            end else begin
                r_o <= res;
            end
        end
    end

    assign o_result.valid             = r_o_valid;
    assign o_result.hour_tens         = r_o.hour_tens;
    assign o_result.hour_units        = r_o.hour_units;
    assign o_result.minute_tens       = r_o.minute_tens;
    assign o_result.minute_units      = r_o.minute_units;
    assign o_result.count_min_tens    = r_o.count_min_tens;
    assign o_result.count_min_units   = r_o.count_min_units;
    assign o_result.count_sec_tens    = r_o.count_sec_tens;
    assign o_result.count_sec_units   = r_o.count_sec_units;
    assign o_result.play_request      = r_o.play_request;
    assign o_result.play_address      = r_o.play_address;
    assign o_result.countdown_running = r_o.countdown_running;

    `BCAC_ASSERT_NOW(a_skid_behind_main, i_clk, i_rst_n, r_s_valid, r_o_valid)
    `BCAC_ASSERT_NEXT(a_fill_skid, i_clk, i_rst_n, push && !pop && r_o_valid, r_s_valid)
    `BCAC_ASSERT_NOW(a_hour_msg_on_top, i_clk, i_rst_n,
        push && res.play_request && res.play_address != MSG_END,
        res.minute_tens == '0 && res.minute_units == '0)
    `BCAC_ASSERT_NOW(a_hour_in_range, i_clk, i_rst_n, r_ht == 2'd2, r_hu <= 4'd3)

endmodule
